>>> rtl/pcsh_pkg.sv
// Shared constants, codes and types of the pc sample histogram.
package pcsh_pkg;

  localparam int unsigned NUM_BUCKETS  = 16384;
  localparam int unsigned BUCKET_SHIFT = 3;
  localparam int unsigned BKT_AW       = $clog2(NUM_BUCKETS);

  localparam int unsigned PC_W     = 64;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned IDX_W    = 20;
  localparam int unsigned CFG_IW   = 3;

  typedef enum logic [2:0] {
    ACT_TICK        = 3'd0,
    ACT_READ        = 3'd1,
    ACT_START       = 3'd2,
    ACT_CLEAR_START = 3'd3,
    ACT_STOP        = 3'd4
  } action_e;

  typedef enum logic [CFG_IW-1:0] {
    CFG_MIN_PC      = 3'd0,
    CFG_MAX_PC      = 3'd1,
    CFG_SPL_LOW     = 3'd2,
    CFG_SPL_HIGH    = 3'd3,
    CFG_TICK_WEIGHT = 3'd4
  } cfg_reg_e;

  // Request to the counter store: one read and one write port.
  typedef struct packed {
    logic              rd_en;
    logic [BKT_AW-1:0] rd_addr;
    logic              wr_en;
    logic [BKT_AW-1:0] wr_addr;
    logic [CNT_W-1:0]  wr_data;
  } mem_req_t;

endpackage

>>> rtl/pcsh_if.sv
// Handshake channels of the pc sample histogram: items, results and configuration.
interface pcsh_in_if import pcsh_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [2:0]          action;
  logic [PC_W-1:0]     sample_pc;
  logic [PC_W-1:0]     saved_pc;
  logic [IDX_W-1:0]    read_index;

  modport source (output valid, action, sample_pc, saved_pc, read_index, input ready);
  modport sink   (input valid, action, sample_pc, saved_pc, read_index, output ready);
endinterface

interface pcsh_out_if import pcsh_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] read_data;
  logic             read_ok;

  modport source (output valid, read_data, read_ok, input ready);
  modport sink   (input valid, read_data, read_ok, output ready);
endinterface

interface pcsh_cfg_if import pcsh_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CFG_IW-1:0] index;
  logic [PC_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/pc_sample_histogram_unit.sv
// Top level of the pc sample histogram: control sequencer around the counter store.
// Bucket read: the RAM read is registered, then the result register; no new item is taken until
// the result is registered. Tick while profiling: pc select, subtract, RAM read, write back.
// Bucket 0 (the total) lives in a register; the other buckets in a single-port-pair RAM.
// After reset, and after clear-and-start, a sweep over all NUM_BUCKETS addresses zeroes the RAM;
// no item is taken during it, configuration writes still are.
module pc_sample_histogram_unit import pcsh_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  pcsh_in_if.sink    in_i,
  pcsh_out_if.source out_o,
  pcsh_cfg_if.sink   cfg_i
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_TICK_SUB,
    S_TICK_RD,
    S_TICK_WR
  } state_e;

  state_e               state_q;
  logic [BKT_AW-1:0]    clr_addr_q;
  logic                 prof_on_q;
  logic [CNT_W-1:0]     total_q;

  logic [PC_W-1:0]      min_pc_q, max_pc_q, spl_low_q, spl_high_q;
  logic [WEIGHT_W-1:0]  weight_q;

  logic [PC_W-1:0]      pc_q;
  logic [PC_W-1:0]      diff_q;
  logic                 in_range_q;
  logic [BKT_AW-1:0]    tgt_q;
  logic                 rd_ok_q;
  logic                 rd_zero_q;

  logic                 out_valid_q;
  logic [CNT_W-1:0]     out_data_q;
  logic                 out_ok_q;

  mem_req_t             mem_req;
  logic [CNT_W-1:0]     mem_rdata;

  logic                 in_xfer;
  logic                 in_win;
  logic [PC_W-1:0]      pc_sel;
  logic                 idx_ok;
  logic [PC_W-1:0]      idx_full;
  logic                 in_tbl;
  logic [BKT_AW-1:0]    tgt;
  logic                 out_free;
  logic [CNT_W-1:0]     weight_ext;

  assign in_i.ready  = (state_q == S_IDLE);
  assign in_xfer     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  // restore-window substitution on the incoming pc
  assign in_win = (in_i.sample_pc >= spl_low_q) && (in_i.sample_pc <= spl_high_q)
                  && (in_i.saved_pc != '0);
  assign pc_sel = in_win ? in_i.saved_pc : in_i.sample_pc;

  assign idx_ok = ({1'b0, in_i.read_index} < (IDX_W+1)'(NUM_BUCKETS));

  assign idx_full = diff_q >> BUCKET_SHIFT;
  assign in_tbl   = idx_full < PC_W'(NUM_BUCKETS);
  assign tgt      = (in_range_q && in_tbl) ? idx_full[BKT_AW-1:0] : BKT_AW'(1);

  assign out_free   = !out_valid_q || out_o.ready;
  assign weight_ext = CNT_W'(weight_q);

  always_comb begin
    mem_req         = '0;
    mem_req.wr_addr = tgt_q;
    mem_req.wr_data = mem_rdata + weight_ext;
    unique case (state_q)
      S_CLEAR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = clr_addr_q;
        mem_req.wr_data = '0;
      end
      S_IDLE: begin
        mem_req.rd_en   = in_xfer && (in_i.action == ACT_READ) && idx_ok;
        mem_req.rd_addr = in_i.read_index[BKT_AW-1:0];
      end
      S_TICK_RD: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = tgt;
      end
      S_TICK_WR: begin
        mem_req.wr_en   = (tgt_q != '0);
      end
      default: ;
    endcase
  end

  pcsh_counter_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_pc_q   <= '0;
      max_pc_q   <= '0;
      spl_low_q  <= '0;
      spl_high_q <= '0;
      weight_q   <= WEIGHT_W'(1);
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        CFG_MIN_PC:      min_pc_q   <= cfg_i.data;
        CFG_MAX_PC:      max_pc_q   <= cfg_i.data;
        CFG_SPL_LOW:     spl_low_q  <= cfg_i.data;
        CFG_SPL_HIGH:    spl_high_q <= cfg_i.data;
        CFG_TICK_WEIGHT: weight_q   <= cfg_i.data[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer, total counter and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_addr_q  <= '0;
      prof_on_q   <= 1'b0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == S_READ) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_addr_q <= clr_addr_q + BKT_AW'(1);
          if (clr_addr_q == BKT_AW'(NUM_BUCKETS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_xfer) begin
            unique case (in_i.action)
              ACT_TICK: begin
                if (prof_on_q) begin
                  state_q <= S_TICK_SUB;
                end
              end
              ACT_READ: begin
                state_q <= S_READ;
              end
              ACT_START: begin
                prof_on_q <= 1'b1;
              end
              ACT_CLEAR_START: begin
                prof_on_q  <= 1'b1;
                total_q    <= '0;
                clr_addr_q <= '0;
                state_q    <= S_CLEAR;
              end
              ACT_STOP: begin
                prof_on_q <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        S_READ: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        S_TICK_SUB: begin
          state_q <= S_TICK_RD;
        end
        S_TICK_RD: begin
          state_q <= S_TICK_WR;
        end
        S_TICK_WR: begin
          // a hit in bucket 0 counts twice there
          if (tgt_q == '0) begin
            total_q <= total_q + {weight_ext[CNT_W-2:0], 1'b0};
          end else begin
            total_q <= total_q + weight_ext;
          end
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      pc_q      <= pc_sel;
      rd_ok_q   <= idx_ok;
      rd_zero_q <= (in_i.read_index == '0);
    end
    if (state_q == S_TICK_SUB) begin
      diff_q     <= pc_q - min_pc_q;
      in_range_q <= (pc_q >= min_pc_q) && (pc_q < max_pc_q);
    end
    if (state_q == S_TICK_RD) begin
      tgt_q <= tgt;
    end
    if ((state_q == S_READ) && out_free) begin
      out_ok_q <= rd_ok_q;
      if (!rd_ok_q) begin
        out_data_q <= '0;
      end else if (rd_zero_q) begin
        out_data_q <= total_q;
      end else begin
        out_data_q <= mem_rdata;
      end
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.read_data = out_data_q;
  assign out_o.read_ok   = out_ok_q;

endmodule

>>> rtl/pcsh_counter_mem.sv
// Counter store: synchronous RAM with one write and one registered read port.
module pcsh_counter_mem import pcsh_pkg::*; (
  input  logic             clk_i,
  input  mem_req_t         req_i,
  output logic [CNT_W-1:0] rdata_o
);

  logic [CNT_W-1:0] mem_q [NUM_BUCKETS];
  logic [CNT_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/pcsh_checker.sv
// Port-level checks of the pc sample histogram, bound to the top level.
module pcsh_checker import pcsh_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid,
  input logic             in_ready,
  input logic [2:0]       in_action,
  input logic             out_valid,
  input logic             out_ready,
  input logic [CNT_W-1:0] out_read_data,
  input logic             out_read_ok
);

  // a result waiting for its transfer stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data) && $stable(out_read_ok))
    else $error("result changed while stalled");

  // a bucket outside the table reads as zero
  a_bad_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_read_ok |-> out_read_data == '0)
    else $error("out-of-table read carries data");

  // only a bucket read produces a result
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && in_action != ACT_READ |=> !$rose(out_valid))
    else $error("result without a read");

endmodule

bind pc_sample_histogram_unit pcsh_checker u_pcsh_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid      (in_i.valid),
  .in_ready      (in_i.ready),
  .in_action     (in_i.action),
  .out_valid     (out_o.valid),
  .out_ready     (out_o.ready),
  .out_read_data (out_o.read_data),
  .out_read_ok   (out_o.read_ok)
);
